/* hdl/vertex_normal_accumulator_defines.svh */
// Assertion macros used by the checker file.
`ifndef VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VNA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vertex normal accumulator check failed");

// Next-cycle implication, disabled while reset is high.
`define VNA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vertex normal accumulator check failed");

// Next-cycle implication that also holds across reset.
`define VNA_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("vertex normal accumulator reset check failed");

`endif

/* hdl/vna_pkg.sv */
package vna_pkg;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_TRI   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [16:0] UNIT_ONE = 17'd16384;

   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] vertex;
      logic       in_range;
   } cmd_ctl_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic [15:0] unit_x;
      logic [15:0] unit_y;
      logic [15:0] unit_z;
      logic        degenerate;
   } norm_res_type;

endpackage

/* hdl/vna_ram.sv */
module vna_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/vna_front.sv */
module vna_front import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [87:0]              req_tdata,
   input  logic [1:0]               req_tuser,
   input  back_status_type          status,
   output logic                     q_valid,
   output cmd_ctl_type              q_ctl,
   output logic [3*COORD_BITS+4*$clog2(MAX_VERTICES)-1:0] q_data,
   input  logic                     q_pop
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int PW = 3*COORD_BITS + 4*AW;

   function automatic logic in_range(input logic [9:0] v);
      return 32'(v) < MAX_VERTICES;
   endfunction

   function automatic logic [AW-1:0] to_addr(input logic [9:0] v);
      logic [AW+9:0] e;
      e = (AW+10)'(v);
      return e[AW-1:0];
   endfunction

   function automatic logic [COORD_BITS-1:0] to_coord(input logic [15:0] p);
      logic [COORD_BITS+15:0] e;
      e = (COORD_BITS+16)'($unsigned(p));
      return e[COORD_BITS-1:0];
   endfunction

   logic [9:0]  f_vertex, f_a, f_b, f_c;
   logic [15:0] f_x, f_y, f_z;
   logic        keep, push;
   cmd_ctl_type ctl_new;
   logic [PW-1:0] data_new;

   cmd_ctl_type   ctl_q  [QUEUE_DEPTH];
   logic [PW-1:0] data_q [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign f_vertex = req_tdata[9:0];
   assign f_x      = req_tdata[25:10];
   assign f_y      = req_tdata[41:26];
   assign f_z      = req_tdata[57:42];
   assign f_a      = req_tdata[67:58];
   assign f_b      = req_tdata[77:68];
   assign f_c      = req_tdata[87:78];

   // Unused opcodes and writes or triangles that touch a missing slot are
   // dropped here; out-of-range reads still go through and answer degenerate.
   always_comb begin
      unique case (req_tuser)
         OP_WRITE: keep = in_range(f_vertex);
         OP_TRI:   keep = in_range(f_a) && in_range(f_b) && in_range(f_c);
         OP_READ:  keep = 1'b1;
         default:  keep = 1'b0;
      endcase
   end

   assign ctl_new.kind     = req_tuser;
   assign ctl_new.vertex   = f_vertex;
   assign ctl_new.in_range = in_range(f_vertex);
   assign data_new = {to_addr(f_vertex), to_addr(f_c), to_addr(f_b), to_addr(f_a),
                      to_coord(f_z), to_coord(f_y), to_coord(f_x)};

   assign req_tready = !status.clearing && (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;

   assign q_valid = count_ff != '0;
   assign q_ctl   = ctl_q[rptr_ff];
   assign q_data  = data_q[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = q_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + QCNT_BITS'(push) - QCNT_BITS'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_q[wptr_ff]  <= ctl_new;
         data_q[wptr_ff] <= data_new;
      end
   end

endmodule

/* hdl/vna_norm.sv */
module vna_norm import vna_pkg::*; #(
   parameter int SUM_BITS = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] sum_x,
   input  logic [SUM_BITS-1:0] sum_y,
   input  logic [SUM_BITS-1:0] sum_z,
   input  logic                take,
   output logic                done,
   output norm_res_type        result
);

   localparam int DW = 47;
   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_SCAN  = 3'd1;
   localparam logic [2:0] N_SQ    = 3'd2;
   localparam logic [2:0] N_SQRT  = 3'd3;
   localparam logic [2:0] N_DSET  = 3'd4;
   localparam logic [2:0] N_DSTEP = 3'd5;
   localparam logic [2:0] N_DONE  = 3'd6;

   localparam logic [SUM_BITS-1:0] TOP_LIM = SUM_BITS'(1) << 30;
   localparam logic [SUM_BITS-1:0] BOT_LIM = SUM_BITS'(1) << 29;

   function automatic logic [SUM_BITS-1:0] mag(input logic [SUM_BITS-1:0] v);
      return v[SUM_BITS-1] ? SUM_BITS'(0) - v : v;
   endfunction

   logic [2:0]          state_ff;
   logic [SUM_BITS-1:0] m_ff [3];
   logic                neg_ff [3];
   logic [15:0]         unit_ff [3];
   logic                deg_ff;
   logic [1:0]          cnt_ff, j_ff;
   logic [59:0]         p_ff;
   logic [63:0]         q_ff, res_ff;
   logic [4:0]          k_ff;
   logic [DW-1:0]       num_ff;
   logic [16:0]         quo_ff;

   logic [SUM_BITS-1:0] big, big_xy;
   logic [29:0]         msq, mdiv;
   logic [63:0]         bitv, trial;
   logic                fits;
   logic [DW-1:0]       dvs;
   logic                dfit;
   logic [16:0]         quo_nx;
   logic [14:0]         u15;
   logic [15:0]         uval;

   assign big_xy = (m_ff[1] > m_ff[0]) ? m_ff[1] : m_ff[0];
   assign big    = (m_ff[2] > big_xy) ? m_ff[2] : big_xy;

   always_comb begin
      unique case (cnt_ff)
         2'd0:    msq = m_ff[0][29:0];
         2'd1:    msq = m_ff[1][29:0];
         default: msq = m_ff[2][29:0];
      endcase
      unique case (j_ff)
         2'd0:    mdiv = m_ff[0][29:0];
         2'd1:    mdiv = m_ff[1][29:0];
         default: mdiv = m_ff[2][29:0];
      endcase
   end

   // Square root one result bit per cycle, remainder kept in q_ff.
   assign bitv  = 64'(1) << {k_ff, 1'b0};
   assign trial = res_ff + bitv;
   assign fits  = q_ff >= trial;

   // Restoring division, one quotient bit per cycle.
   assign dvs    = DW'(res_ff[30:0]) << k_ff;
   assign dfit   = num_ff >= dvs;
   assign quo_nx = {quo_ff[15:0], dfit};
   assign u15    = (quo_nx > UNIT_ONE) ? UNIT_ONE[14:0] : quo_nx[14:0];
   assign uval   = neg_ff[j_ff] ? 16'd0 - {1'b0, u15} : {1'b0, u15};

   assign done              = state_ff == N_DONE;
   assign result.unit_x     = unit_ff[0];
   assign result.unit_y     = unit_ff[1];
   assign result.unit_z     = unit_ff[2];
   assign result.degenerate = deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         unique case (state_ff)
            N_IDLE: begin
               if (start) begin
                  m_ff[0]   <= mag(sum_x);
                  m_ff[1]   <= mag(sum_y);
                  m_ff[2]   <= mag(sum_z);
                  neg_ff[0] <= sum_x[SUM_BITS-1];
                  neg_ff[1] <= sum_y[SUM_BITS-1];
                  neg_ff[2] <= sum_z[SUM_BITS-1];
                  state_ff  <= N_SCAN;
               end
            end
            N_SCAN: begin
               priority if (big == '0) begin
                  unit_ff[0] <= '0;
                  unit_ff[1] <= '0;
                  unit_ff[2] <= '0;
                  deg_ff     <= 1'b1;
                  state_ff   <= N_DONE;
               end else if (big >= TOP_LIM) begin
                  m_ff[0] <= m_ff[0] >> 1;
                  m_ff[1] <= m_ff[1] >> 1;
                  m_ff[2] <= m_ff[2] >> 1;
               end else if (big < BOT_LIM) begin
                  m_ff[0] <= m_ff[0] << 1;
                  m_ff[1] <= m_ff[1] << 1;
                  m_ff[2] <= m_ff[2] << 1;
               end else begin
                  deg_ff   <= 1'b0;
                  cnt_ff   <= '0;
                  q_ff     <= '0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               p_ff <= 60'(msq) * 60'(msq);
               if (cnt_ff != 2'd0) begin
                  q_ff <= q_ff + 64'(p_ff);
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 2'd3) begin
                  res_ff   <= '0;
                  k_ff     <= 5'd31;
                  state_ff <= N_SQRT;
               end
            end
            N_SQRT: begin
               if (fits) begin
                  q_ff   <= q_ff - trial;
                  res_ff <= (res_ff >> 1) + bitv;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               k_ff <= k_ff - 1'b1;
               if (k_ff == 5'd0) begin
                  j_ff     <= '0;
                  state_ff <= N_DSET;
               end
            end
            N_DSET: begin
               num_ff   <= DW'({mdiv, 14'd0}) + DW'(res_ff[30:1]);
               quo_ff   <= '0;
               k_ff     <= 5'd16;
               state_ff <= N_DSTEP;
            end
            N_DSTEP: begin
               if (dfit) begin
                  num_ff <= num_ff - dvs;
               end
               quo_ff <= quo_nx;
               k_ff   <= k_ff - 1'b1;
               if (k_ff == 5'd0) begin
                  unit_ff[j_ff] <= uval;
                  j_ff          <= j_ff + 1'b1;
                  state_ff      <= (j_ff == 2'd2) ? N_DONE : N_DSET;
               end
            end
            N_DONE: begin
               if (take) begin
                  state_ff <= N_IDLE;
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

endmodule

/* hdl/vna_back.sv */
module vna_back import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16,
   parameter int SUM_BITS     = 40
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  cmd_ctl_type     q_ctl,
   input  logic [3*COORD_BITS+4*$clog2(MAX_VERTICES)-1:0] q_data,
   output logic            q_pop,
   output back_status_type status,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [63:0]     rsp_tdata,
   output logic [0:0]      rsp_tuser
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int PW = 3*COORD_BITS + 4*AW;
   localparam int C  = COORD_BITS;
   localparam int S  = SUM_BITS;
   localparam int DB = C + 1;
   localparam int PB = 2 * DB;
   localparam int CB = PB + 1;
   localparam int WB = ((S > CB) ? S : CB) + 1;
   localparam logic signed [WB-1:0] SAT_HI = WB'({1'b0, {(S-1){1'b1}}});
   localparam logic signed [WB-1:0] SAT_LO = -SAT_HI - 1;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_WR    = 4'd2;
   localparam logic [3:0] S_PRD_A = 4'd3;
   localparam logic [3:0] S_PRD_B = 4'd4;
   localparam logic [3:0] S_PRD_C = 4'd5;
   localparam logic [3:0] S_PRD_W = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_SRD   = 4'd8;
   localparam logic [3:0] S_SWR   = 4'd9;
   localparam logic [3:0] S_RRD   = 4'd10;
   localparam logic [3:0] S_RWAIT = 4'd11;
   localparam logic [3:0] S_NORM  = 4'd12;

   function automatic logic [S-1:0] sat_add(input logic signed [S-1:0] acc,
                                            input logic signed [CB-1:0] d);
      logic signed [WB-1:0] s;
      s = WB'(acc) + WB'(d);
      if (s > SAT_HI) begin
         return SAT_HI[S-1:0];
      end else if (s < SAT_LO) begin
         return SAT_LO[S-1:0];
      end
      return s[S-1:0];
   endfunction

   logic [3:0]    state_ff;
   logic [AW-1:0] clr_ff;
   cmd_ctl_type   cmd_ctl_ff;
   logic [PW-1:0] cmd_data_ff;
   logic [2:0]    k_ff;
   logic [1:0]    j_ff;
   logic signed [C-1:0]  pa_ff [3];
   logic signed [C-1:0]  pb_ff [3];
   logic signed [DB-1:0] u_ff [3];
   logic signed [DB-1:0] w_ff [3];
   logic signed [PB-1:0] prod_ff;
   logic signed [CB-1:0] cross_ff [3];

   logic          rsp_valid_ff;
   logic [63:0]   rsp_data_ff;
   logic          rsp_deg_ff;

   logic [AW-1:0] c_vaddr, c_a, c_b, c_c, corner;
   logic [3*C-1:0] c_pos;
   logic signed [DB-1:0] opa, opb;

   logic          pos_we;
   logic [AW-1:0] pos_raddr;
   logic [3*C-1:0] pos_rdata;
   logic          sum_we;
   logic [AW-1:0] sum_waddr, sum_raddr;
   logic [3*S-1:0] sum_wdata, sum_rdata;

   logic          norm_start, norm_take, norm_done;
   logic [S-1:0]  nx, ny, nz;
   norm_res_type  norm_res;
   logic          rsp_load;

   assign c_pos   = cmd_data_ff[3*C-1:0];
   assign c_a     = cmd_data_ff[3*C+AW-1:3*C];
   assign c_b     = cmd_data_ff[3*C+2*AW-1:3*C+AW];
   assign c_c     = cmd_data_ff[3*C+3*AW-1:3*C+2*AW];
   assign c_vaddr = cmd_data_ff[3*C+4*AW-1:3*C+3*AW];

   always_comb begin
      unique case (j_ff)
         2'd0:    corner = c_a;
         2'd1:    corner = c_b;
         default: corner = c_c;
      endcase
   end

   // Six products of the cross product through one multiplier.
   always_comb begin
      unique case (k_ff)
         3'd0:    begin opa = u_ff[1]; opb = w_ff[2]; end
         3'd1:    begin opa = u_ff[2]; opb = w_ff[1]; end
         3'd2:    begin opa = u_ff[2]; opb = w_ff[0]; end
         3'd3:    begin opa = u_ff[0]; opb = w_ff[2]; end
         3'd4:    begin opa = u_ff[0]; opb = w_ff[1]; end
         default: begin opa = u_ff[1]; opb = w_ff[0]; end
      endcase
   end

   always_comb begin
      pos_we    = state_ff == S_WR;
      pos_raddr = c_b;
      unique case (state_ff)
         S_PRD_A: pos_raddr = c_a;
         S_PRD_C: pos_raddr = c_c;
         default: pos_raddr = c_b;
      endcase
      sum_we    = (state_ff == S_CLEAR) || (state_ff == S_WR) || (state_ff == S_SWR);
      sum_waddr = (state_ff == S_CLEAR) ? clr_ff : ((state_ff == S_WR) ? c_vaddr : corner);
      sum_raddr = (state_ff == S_RRD) ? c_vaddr : corner;
      if (state_ff == S_SWR) begin
         sum_wdata = {sat_add($signed(sum_rdata[3*S-1:2*S]), cross_ff[2]),
                      sat_add($signed(sum_rdata[2*S-1:S]), cross_ff[1]),
                      sat_add($signed(sum_rdata[S-1:0]), cross_ff[0])};
      end else begin
         sum_wdata = '0;
      end
   end

   assign nx = cmd_ctl_ff.in_range ? sum_rdata[S-1:0]     : '0;
   assign ny = cmd_ctl_ff.in_range ? sum_rdata[2*S-1:S]   : '0;
   assign nz = cmd_ctl_ff.in_range ? sum_rdata[3*S-1:2*S] : '0;
   assign norm_start = state_ff == S_RWAIT;
   assign rsp_load   = (state_ff == S_NORM) && norm_done && (!rsp_valid_ff || rsp_tready);
   assign norm_take  = rsp_load;

   assign q_pop           = (state_ff == S_IDLE) && q_valid;
   assign status.clearing = state_ff == S_CLEAR;

   vna_ram #(.WIDTH(3*C), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (c_vaddr),
      .wdata (c_pos),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   vna_ram #(.WIDTH(3*S), .DEPTH(MAX_VERTICES)) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_waddr),
      .wdata (sum_wdata),
      .raddr (sum_raddr),
      .rdata (sum_rdata)
   );

   vna_norm #(.SUM_BITS(S)) u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .sum_x  (nx),
      .sum_y  (ny),
      .sum_z  (nz),
      .take   (norm_take),
      .done   (norm_done),
      .result (norm_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(MAX_VERTICES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ctl_ff  <= q_ctl;
                  cmd_data_ff <= q_data;
                  unique case (q_ctl.kind)
                     OP_WRITE: state_ff <= S_WR;
                     OP_TRI:   state_ff <= S_PRD_A;
                     OP_READ:  state_ff <= S_RRD;
                     default:  state_ff <= S_IDLE;
                  endcase
               end
            end
            S_WR:    state_ff <= S_IDLE;
            S_PRD_A: state_ff <= S_PRD_B;
            S_PRD_B: begin
               pa_ff[0] <= $signed(pos_rdata[C-1:0]);
               pa_ff[1] <= $signed(pos_rdata[2*C-1:C]);
               pa_ff[2] <= $signed(pos_rdata[3*C-1:2*C]);
               state_ff <= S_PRD_C;
            end
            S_PRD_C: begin
               pb_ff[0] <= $signed(pos_rdata[C-1:0]);
               pb_ff[1] <= $signed(pos_rdata[2*C-1:C]);
               pb_ff[2] <= $signed(pos_rdata[3*C-1:2*C]);
               state_ff <= S_PRD_W;
            end
            S_PRD_W: begin
               u_ff[0] <= DB'(pb_ff[0]) - DB'(pa_ff[0]);
               u_ff[1] <= DB'(pb_ff[1]) - DB'(pa_ff[1]);
               u_ff[2] <= DB'(pb_ff[2]) - DB'(pa_ff[2]);
               w_ff[0] <= DB'($signed(pos_rdata[C-1:0])) - DB'(pa_ff[0]);
               w_ff[1] <= DB'($signed(pos_rdata[2*C-1:C])) - DB'(pa_ff[1]);
               w_ff[2] <= DB'($signed(pos_rdata[3*C-1:2*C])) - DB'(pa_ff[2]);
               k_ff     <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff <= opa * opb;
               unique case (k_ff)
                  3'd1:    cross_ff[0] <= CB'(prod_ff);
                  3'd2:    cross_ff[0] <= cross_ff[0] - CB'(prod_ff);
                  3'd3:    cross_ff[1] <= CB'(prod_ff);
                  3'd4:    cross_ff[1] <= cross_ff[1] - CB'(prod_ff);
                  3'd5:    cross_ff[2] <= CB'(prod_ff);
                  3'd6:    cross_ff[2] <= cross_ff[2] - CB'(prod_ff);
                  default: ;
               endcase
               k_ff <= k_ff + 1'b1;
               if (k_ff == 3'd6) begin
                  j_ff     <= '0;
                  state_ff <= S_SRD;
               end
            end
            S_SRD:   state_ff <= S_SWR;
            S_SWR: begin
               // Corners are updated one after another so a repeated
               // corner sees its own earlier update.
               j_ff     <= j_ff + 1'b1;
               state_ff <= (j_ff == 2'd2) ? S_IDLE : S_SRD;
            end
            S_RRD:   state_ff <= S_RWAIT;
            S_RWAIT: state_ff <= S_NORM;
            S_NORM: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, norm_res.unit_z, norm_res.unit_y, norm_res.unit_x,
                         cmd_ctl_ff.vertex};
         rsp_deg_ff  <= norm_res.degenerate;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_deg_ff;

endmodule

/* hdl/vertex_normal_accumulator.sv */
// A read goes through scaling (up to 29 shifts), a 32-step square root and three divides
// before rsp_tvalid; a zero normal skips straight to the result.
// The back end runs one item at a time; a four-entry queue lets input keep flowing meanwhile.
// Reset is synchronous, active high; afterwards a clearing pass over all MAX_VERTICES
// slots zeroes the accumulators while req_tready stays low.
module vertex_normal_accumulator import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16,
   parameter int SUM_BITS     = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // vertex[9:0], pos_x[25:10], pos_y[41:26], pos_z[57:42],
   // corner_a[67:58], corner_b[77:68], corner_c[87:78]
   input  logic [87:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_vertex[9:0], unit_x[25:10], unit_y[41:26], unit_z[57:42], zeros above
   output logic [63:0] rsp_tdata,
   // degenerate[0]
   output logic [0:0]  rsp_tuser
);

   localparam int PW = 3*COORD_BITS + 4*$clog2(MAX_VERTICES);

   back_status_type status;
   logic            q_valid, q_pop;
   cmd_ctl_type     q_ctl;
   logic [PW-1:0]   q_data;

   vna_front #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .q_valid    (q_valid),
      .q_ctl      (q_ctl),
      .q_data     (q_data),
      .q_pop      (q_pop)
   );

   vna_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS),
              .SUM_BITS(SUM_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ctl      (q_ctl),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hdl/vna_checker.sv */
`include "vertex_normal_accumulator_defines.svh"

module vna_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic signed [15:0] unit_x, unit_y, unit_z;
   logic               units_ok;

   assign unit_x   = rsp_tdata[25:10];
   assign unit_y   = rsp_tdata[41:26];
   assign unit_z   = rsp_tdata[57:42];
   assign units_ok = (unit_x <= 16'sd16384) && (unit_x >= -16'sd16384) &&
                     (unit_y <= 16'sd16384) && (unit_y >= -16'sd16384) &&
                     (unit_z <= 16'sd16384) && (unit_z >= -16'sd16384);

   // No result may be offered right after reset, and intake waits for the clear.
   `VNA_ASSERT_RESET(a_reset_quiet, reset, !rsp_tvalid && !req_tready)

   // A degenerate answer carries an all-zero vector.
   `VNA_ASSERT_NOW(a_degenerate_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata[57:10] == 48'd0)

   // Each unit component stays within plus or minus one in Q1.14.
   `VNA_ASSERT_NOW(a_unit_range, rsp_tvalid, units_ok)

   // A stalled result transaction holds its payload.
   `VNA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

/* test/tb_vertex_normal_accumulator.sv */
module tb_vertex_normal_accumulator;
   import vna_pkg::*;

   localparam int     NUM_SLOTS  = 1024;
   localparam longint SUM_HI     = (64'sd1 <<< 39) - 1;
   localparam longint SUM_LO     = -SUM_HI - 1;
   localparam int     LIMIT      = 1500000;
   localparam int     DRAIN      = 400;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct {
      logic [9:0]  read_vertex;
      logic [15:0] unit_x;
      logic [15:0] unit_y;
      logic [15:0] unit_z;
      logic        degenerate;
   } normal_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   // Shadow copy of the mesh held by the block.
   logic signed [15:0] pos_x_mem [NUM_SLOTS];
   logic signed [15:0] pos_y_mem [NUM_SLOTS];
   logic signed [15:0] pos_z_mem [NUM_SLOTS];
   longint             acc_x [NUM_SLOTS];
   longint             acc_y [NUM_SLOTS];
   longint             acc_z [NUM_SLOTS];
   bit                 pos_written [NUM_SLOTS];
   int                 written_slots [$];

   normal_result_type expected_normals [$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   vertex_normal_accumulator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time,
                  expected_normals.size());
         $display("[vertex_normal_accumulator] ERROR");
         $finish;
      end
   end

   function automatic longint sat_add(longint acc, longint d);
      if (d > 0 && acc > SUM_HI - d) return SUM_HI;
      if (d < 0 && acc < SUM_LO - d) return SUM_LO;
      return acc + d;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned q);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > q) bitv >>= 2;
      while (bitv != 0) begin
         if (q >= res + bitv) begin
            q -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_component(bit neg, longint unsigned m,
                                                  longint unsigned len);
      longint unsigned u;
      u = (m * 16384 + (len >> 1)) / len;
      if (u > 16384) u = 16384;
      if (neg) u = -u;
      return u[15:0];
   endfunction

   function automatic normal_result_type normalize_slot(logic [9:0] slot);
      normal_result_type r;
      longint sx, sy, sz;
      longint unsigned mx, my, mz, big, len;
      sx = acc_x[slot];
      sy = acc_y[slot];
      sz = acc_z[slot];
      mx = sx < 0 ? -sx : sx;
      my = sy < 0 ? -sy : sy;
      mz = sz < 0 ? -sz : sz;
      big = mx;
      if (my > big) big = my;
      if (mz > big) big = mz;
      r.read_vertex = slot;
      if (big == 0) begin
         r.unit_x = '0;
         r.unit_y = '0;
         r.unit_z = '0;
         r.degenerate = 1'b1;
         return r;
      end
      while (big >= (64'd1 << 30)) begin
         big >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
      end
      while (big < (64'd1 << 29)) begin
         big <<= 1; mx <<= 1; my <<= 1; mz <<= 1;
      end
      len = int_sqrt(mx * mx + my * my + mz * mz);
      r.unit_x = unit_component(sx < 0, mx, len);
      r.unit_y = unit_component(sy < 0, my, len);
      r.unit_z = unit_component(sz < 0, mz, len);
      r.degenerate = 1'b0;
      return r;
   endfunction

   task automatic update_mesh(logic [1:0] op, logic [87:0] d);
      logic [9:0] v, a, b, c;
      longint ux, uy, uz, wx, wy, wz, cx, cy, cz;
      v = d[9:0];
      a = d[67:58];
      b = d[77:68];
      c = d[87:78];
      case (op)
         OP_WRITE: begin
            pos_x_mem[v] = d[25:10];
            pos_y_mem[v] = d[41:26];
            pos_z_mem[v] = d[57:42];
            acc_x[v] = 0;
            acc_y[v] = 0;
            acc_z[v] = 0;
            if (!pos_written[v]) written_slots.insert(written_slots.size(), int'(v));
            pos_written[v] = 1'b1;
         end
         OP_TRI: begin
            ux = longint'(pos_x_mem[b]) - pos_x_mem[a];
            uy = longint'(pos_y_mem[b]) - pos_y_mem[a];
            uz = longint'(pos_z_mem[b]) - pos_z_mem[a];
            wx = longint'(pos_x_mem[c]) - pos_x_mem[a];
            wy = longint'(pos_y_mem[c]) - pos_y_mem[a];
            wz = longint'(pos_z_mem[c]) - pos_z_mem[a];
            cx = uy * wz - uz * wy;
            cy = uz * wx - ux * wz;
            cz = ux * wy - uy * wx;
            acc_x[a] = sat_add(acc_x[a], cx);
            acc_y[a] = sat_add(acc_y[a], cy);
            acc_z[a] = sat_add(acc_z[a], cz);
            acc_x[b] = sat_add(acc_x[b], cx);
            acc_y[b] = sat_add(acc_y[b], cy);
            acc_z[b] = sat_add(acc_z[b], cz);
            acc_x[c] = sat_add(acc_x[c], cx);
            acc_y[c] = sat_add(acc_y[c], cy);
            acc_z[c] = sat_add(acc_z[c], cz);
         end
         OP_READ: expected_normals.insert(expected_normals.size(), normalize_slot(v));
         default: ;
      endcase
   endtask

   // Drives one transaction; tvalid is left high so back-to-back items need
   // no second assignment in the same step. Idle gaps lower it first.
   task automatic send_item(logic [1:0] op, logic [87:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 88'({$urandom, $urandom, $urandom});
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      update_mesh(op, d);
   endtask

   function automatic logic [87:0] noise_data();
      return 88'({$urandom, $urandom, $urandom});
   endfunction

   task automatic write_pos(logic [9:0] v, logic [15:0] x, logic [15:0] y, logic [15:0] z);
      logic [87:0] d;
      d = noise_data();
      d[57:0] = {z, y, x, v};
      send_item(OP_WRITE, d);
   endtask

   task automatic add_tri(logic [9:0] a, logic [9:0] b, logic [9:0] c);
      logic [87:0] d;
      d = noise_data();
      d[87:58] = {c, b, a};
      send_item(OP_TRI, d);
   endtask

   task automatic read_normal(logic [9:0] v);
      logic [87:0] d;
      d = noise_data();
      d[9:0] = v;
      send_item(OP_READ, d);
   endtask

   always @(posedge clock) begin
      normal_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_normals.size() == 0) begin
            $display("%0t unexpected result: expected none, actual tdata=%h tuser=%b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_r = expected_normals.pop_front();
            if (rsp_tdata[9:0] !== exp_r.read_vertex ||
                rsp_tdata[25:10] !== exp_r.unit_x ||
                rsp_tdata[41:26] !== exp_r.unit_y ||
                rsp_tdata[57:42] !== exp_r.unit_z ||
                rsp_tuser[0] !== exp_r.degenerate) begin
               $display("%0t mismatch: exp v=%0d u=%h %h %h d=%b, got v=%0d u=%h %h %h d=%b",
                        $time, exp_r.read_vertex, exp_r.unit_x, exp_r.unit_y,
                        exp_r.unit_z, exp_r.degenerate, rsp_tdata[9:0],
                        rsp_tdata[25:10], rsp_tdata[41:26], rsp_tdata[57:42],
                        rsp_tuser[0]);
               error_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic test_directed();
      write_pos(0, 16'h8000, 16'h8000, 16'h8000);
      write_pos(1, 16'h7FFF, 16'h8000, 16'h8000);
      write_pos(2, 16'h8000, 16'h7FFF, 16'h8000);
      read_normal(1023);
      read_normal(0);
      add_tri(0, 1, 2);
      read_normal(0);
      read_normal(2);
      send_item(OP_NONE, noise_data());
      write_pos(3, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      add_tri(3, 1, 2);
      read_normal(3);
      read_normal(1);
      // Collinear corners give a zero cross product.
      write_pos(4, 16'h0000, 16'h0000, 16'h0000);
      write_pos(5, 16'h0001, 16'h0001, 16'h0001);
      write_pos(6, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_tri(4, 5, 6);
      read_normal(4);
      // Rewriting a position clears its accumulator.
      write_pos(0, 16'h1000, 16'h0000, 16'hF000);
      read_normal(0);
      add_tri(2, 2, 2);
      read_normal(2);
      add_tri(4, 6, 5);
      read_normal(5);
   endtask

   task automatic test_saturation();
      write_pos(10, 16'h8000, 16'h8000, 16'h0000);
      write_pos(11, 16'h7FFF, 16'h8000, 16'h0000);
      write_pos(12, 16'h8000, 16'h7FFF, 16'h7FFF);
      repeat (140) add_tri(10, 11, 12);
      read_normal(10);
      read_normal(12);
      write_pos(10, 16'h8000, 16'h8000, 16'h0000);
      write_pos(11, 16'h7FFF, 16'h8000, 16'h0000);
      write_pos(12, 16'h8000, 16'h7FFF, 16'h7FFF);
      repeat (140) add_tri(10, 12, 11);
      read_normal(11);
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(63) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [9:0] rand_slot();
      return ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(15));
   endfunction

   function automatic logic [9:0] rand_written();
      return 10'(written_slots[$urandom_range(written_slots.size() - 1)]);
   endfunction

   task automatic test_random_mesh(int n_items, int idle_pct, int stall_pct);
      int sent;
      int pick;
      logic [9:0] a, b, c;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            a = rand_slot();
            b = rand_slot();
            c = rand_slot();
            write_pos(a, rand_coord(), rand_coord(), rand_coord());
            write_pos(b, rand_coord(), rand_coord(), rand_coord());
            write_pos(c, rand_coord(), rand_coord(), rand_coord());
            add_tri(a, b, c);
            read_normal(a);
            sent += 5;
         end else if (pick < 80) begin
            add_tri(rand_written(), rand_written(), rand_written());
            sent++;
         end else if (pick < 95) begin
            read_normal(($urandom_range(3) == 0) ? 10'($urandom) : rand_written());
            sent++;
         end else begin
            send_item(OP_NONE, noise_data());
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_saturation();
      test_random_mesh(150, 0, 0);
      test_random_mesh(150, 46, 0);
      test_random_mesh(150, 0, 46);
      test_random_mesh(150, 9, 9);
      req_tvalid <= 1'b0;
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (error_count == 0 && expected_normals.size() == 0) begin
         $display("[vertex_normal_accumulator] OK");
      end else begin
         $display("[vertex_normal_accumulator] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/vna_pkg.sv
hdl/vna_ram.sv
hdl/vna_front.sv
hdl/vna_norm.sv
hdl/vna_back.sv
hdl/vertex_normal_accumulator.sv
hdl/vna_checker.sv
test/tb_vertex_normal_accumulator.sv
